/* rtl/core/u2k_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package u2k_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CP_W = 21;

	localparam logic [7:0] QMARK = 8'h3F;
	localparam logic [7:0] LEAD_TWO_LIMIT = 8'hE0;
	localparam logic [7:0] LEAD_THREE_LIMIT = 8'hF0;
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [CP_W-1:0] CP_CURRENCY = CP_W'(24'h0000A4);
	localparam logic [7:0] KOI8_CURRENCY = 8'h24;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] koi8_code;
		logic       unmapped;
		logic       truncated;
		logic       text_failed;
		logic       last_of_text;
	} char_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            truncated;
		logic            last_of_text;
	} cp_item_t;

	typedef struct packed {
		logic     push;
		cp_item_t item;
	} queue_wr_t;

	typedef struct packed {
		logic     not_empty;
		cp_item_t item;
	} queue_rd_t;

	localparam logic [15:0] KOI8_HIGH [128] = '{
		16'h2500, 16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524,
		16'h252C, 16'h2534, 16'h253C, 16'h2580, 16'h2584, 16'h2588, 16'h258C, 16'h2590,
		16'h2591, 16'h2592, 16'h2593, 16'h2320, 16'h25A0, 16'h2219, 16'h221A, 16'h2248,
		16'h2264, 16'h2265, 16'h00A0, 16'h2321, 16'h00B0, 16'h00B2, 16'h00B7, 16'h00F7,
		16'h2550, 16'h2551, 16'h2552, 16'h0451, 16'h2553, 16'h2554, 16'h2555, 16'h2556,
		16'h2557, 16'h2558, 16'h2559, 16'h255A, 16'h255B, 16'h255C, 16'h255D, 16'h255E,
		16'h255F, 16'h2560, 16'h2561, 16'h0401, 16'h2562, 16'h2563, 16'h2564, 16'h2565,
		16'h2566, 16'h2567, 16'h2568, 16'h2569, 16'h256A, 16'h256B, 16'h256C, 16'h00A9,
		16'h044E, 16'h0430, 16'h0431, 16'h0446, 16'h0434, 16'h0435, 16'h0444, 16'h0433,
		16'h0445, 16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E,
		16'h043F, 16'h044F, 16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0436, 16'h0432,
		16'h044C, 16'h044B, 16'h0437, 16'h0448, 16'h044D, 16'h0449, 16'h0447, 16'h044A,
		16'h042E, 16'h0410, 16'h0411, 16'h0426, 16'h0414, 16'h0415, 16'h0424, 16'h0413,
		16'h0425, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
		16'h041F, 16'h042F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0416, 16'h0412,
		16'h042C, 16'h042B, 16'h0417, 16'h0428, 16'h042D, 16'h0429, 16'h0427, 16'h042A
	};

endpackage

`default_nettype wire

/* rtl/core/u2k_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module u2k_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire u2k_pkg::byte_item_t byte_item,
	input  wire logic                queue_full,
	output u2k_pkg::queue_wr_t       queue_wr
);

	logic [1:0]                  pending_q;
	logic [u2k_pkg::CP_W-1:0]    accum_q;
	logic [1:0]                  pending_next;
	logic [u2k_pkg::CP_W-1:0]    accum_next;
	logic                        accept;
	logic                        emit;
	logic [7:0]                  b;

	assign b = byte_item.text_byte;
	assign byte_stall = queue_full;
	assign accept = byte_valid && !queue_full;

	always_comb begin
		if (pending_q == 2'd0) begin
			priority if (b < u2k_pkg::ASCII_LIMIT) begin
				accum_next = u2k_pkg::CP_W'(b);
				pending_next = 2'd0;
			end else if (b < u2k_pkg::LEAD_TWO_LIMIT) begin
				accum_next = u2k_pkg::CP_W'(b[4:0]);
				pending_next = 2'd1;
			end else if (b < u2k_pkg::LEAD_THREE_LIMIT) begin
				accum_next = u2k_pkg::CP_W'(b[3:0]);
				pending_next = 2'd2;
			end else begin
				accum_next = u2k_pkg::CP_W'(b[2:0]);
				pending_next = 2'd3;
			end
		end else begin
			accum_next = {accum_q[u2k_pkg::CP_W-7:0], b[5:0]};
			pending_next = pending_q - 2'd1;
		end
	end

	assign emit = (pending_next == 2'd0) || byte_item.end_of_text;

	always_comb begin
		queue_wr.push = accept && emit;
		queue_wr.item.code_point = accum_next;
		queue_wr.item.truncated = (pending_next != 2'd0);
		queue_wr.item.last_of_text = byte_item.end_of_text;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			accum_q <= '0;
		end else if (accept) begin
			if (byte_item.end_of_text) begin
				pending_q <= 2'd0;
				accum_q <= '0;
			end else begin
				pending_q <= pending_next;
				accum_q <= accum_next;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/u2k_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module u2k_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire u2k_pkg::queue_wr_t queue_wr,
	output logic                    queue_full,
	input  wire logic               pop,
	output u2k_pkg::queue_rd_t      queue_rd
);

	u2k_pkg::cp_item_t                  entries_q [u2k_pkg::QUEUE_DEPTH];
	logic [u2k_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [u2k_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [u2k_pkg::QUEUE_CNT_W-1:0]    count_q;
	logic                               do_push;
	logic                               do_pop;

	assign queue_full = (count_q == u2k_pkg::QUEUE_CNT_W'(u2k_pkg::QUEUE_DEPTH));
	assign queue_rd.not_empty = (count_q != '0);
	assign queue_rd.item = entries_q[rd_ptr_q];
	assign do_push = queue_wr.push && !queue_full;
	assign do_pop = pop && queue_rd.not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= queue_wr.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == u2k_pkg::QUEUE_PTR_W'(u2k_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + u2k_pkg::QUEUE_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == u2k_pkg::QUEUE_PTR_W'(u2k_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + u2k_pkg::QUEUE_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + u2k_pkg::QUEUE_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - u2k_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/u2k_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module u2k_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire u2k_pkg::queue_rd_t queue_rd,
	output logic                    pop,
	output logic                    char_valid,
	input  wire logic               char_stall,
	output u2k_pkg::char_item_t     char_item
);

	logic                    out_valid_q;
	u2k_pkg::char_item_t     out_q;
	logic                    error_q;
	logic [6:0]              hit_index;
	logic                    hit_any;
	logic [7:0]              code;
	logic                    unm;
	logic                    failed;
	u2k_pkg::cp_item_t       cur;

	assign cur = queue_rd.item;
	assign pop = queue_rd.not_empty && (!out_valid_q || !char_stall);
	assign char_valid = out_valid_q;
	assign char_item = out_q;

	// Table entries are distinct, so the matching indexes can be ORed together.
	always_comb begin
		hit_index = '0;
		hit_any = 1'b0;
		for (int k = 0; k < 128; k++) begin
			if (cur.code_point == u2k_pkg::CP_W'(u2k_pkg::KOI8_HIGH[k])) begin
				hit_index = hit_index | 7'(k);
				hit_any = 1'b1;
			end
		end
	end

	always_comb begin
		unm = 1'b0;
		priority if (cur.truncated) begin
			code = u2k_pkg::QMARK;
		end else if (cur.code_point < u2k_pkg::CP_W'(u2k_pkg::ASCII_LIMIT)) begin
			code = cur.code_point[7:0];
		end else if (cur.code_point == u2k_pkg::CP_CURRENCY) begin
			code = u2k_pkg::KOI8_CURRENCY;
		end else if (hit_any) begin
			code = {1'b1, hit_index};
		end else begin
			code = u2k_pkg::QMARK;
			unm = 1'b1;
		end
		failed = error_q || unm || cur.truncated;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.koi8_code <= code;
			out_q.unmapped <= unm;
			out_q.truncated <= cur.truncated;
			out_q.text_failed <= failed;
			out_q.last_of_text <= cur.last_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			error_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				error_q <= cur.last_of_text ? 1'b0 : failed;
			end else if (!char_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/utf8_to_koi8r_decoder_unit.sv */
// Path: a byte that completes a character, or ends a text, is stored in the queue, then registered at the output.
// Throughput: one byte per cycle while byte_stall is low; the front decoder and the table lookup are separate stages.
// A two-entry queue between them lets each side stall on its own.
// Reset: arst_n clears the sequence state, the sticky text error, the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_koi8r_decoder_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire u2k_pkg::byte_item_t byte_item,
	output logic                     char_valid,
	input  wire logic                char_stall,
	output u2k_pkg::char_item_t      char_item
);

	u2k_pkg::queue_wr_t queue_wr;
	u2k_pkg::queue_rd_t queue_rd;
	logic               queue_full;
	logic               pop;

	u2k_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.queue_full (queue_full),
		.queue_wr   (queue_wr)
	);

	u2k_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_wr   (queue_wr),
		.queue_full (queue_full),
		.pop        (pop),
		.queue_rd   (queue_rd)
	);

	u2k_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_rd   (queue_rd),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item)
	);

endmodule

`default_nettype wire

/* verif/utf8_to_koi8r_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module utf8_to_koi8r_decoder_unit_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_WAIT = 16;
	localparam logic [7:0] QUESTION_MARK = 8'h3F;
	localparam logic [7:0] ASCII_END = 8'h80;
	localparam logic [7:0] TWO_BYTE_END = 8'hE0;
	localparam logic [7:0] THREE_BYTE_END = 8'hF0;
	localparam logic [20:0] CURRENCY_CP = 21'h0000A4;
	localparam logic [7:0] CURRENCY_KOI8 = 8'h24;

	localparam logic [15:0] KOI8R_UPPER [128] = '{
		16'h2500, 16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524,
		16'h252C, 16'h2534, 16'h253C, 16'h2580, 16'h2584, 16'h2588, 16'h258C, 16'h2590,
		16'h2591, 16'h2592, 16'h2593, 16'h2320, 16'h25A0, 16'h2219, 16'h221A, 16'h2248,
		16'h2264, 16'h2265, 16'h00A0, 16'h2321, 16'h00B0, 16'h00B2, 16'h00B7, 16'h00F7,
		16'h2550, 16'h2551, 16'h2552, 16'h0451, 16'h2553, 16'h2554, 16'h2555, 16'h2556,
		16'h2557, 16'h2558, 16'h2559, 16'h255A, 16'h255B, 16'h255C, 16'h255D, 16'h255E,
		16'h255F, 16'h2560, 16'h2561, 16'h0401, 16'h2562, 16'h2563, 16'h2564, 16'h2565,
		16'h2566, 16'h2567, 16'h2568, 16'h2569, 16'h256A, 16'h256B, 16'h256C, 16'h00A9,
		16'h044E, 16'h0430, 16'h0431, 16'h0446, 16'h0434, 16'h0435, 16'h0444, 16'h0433,
		16'h0445, 16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E,
		16'h043F, 16'h044F, 16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0436, 16'h0432,
		16'h044C, 16'h044B, 16'h0437, 16'h0448, 16'h044D, 16'h0449, 16'h0447, 16'h044A,
		16'h042E, 16'h0410, 16'h0411, 16'h0426, 16'h0414, 16'h0415, 16'h0424, 16'h0413,
		16'h0425, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
		16'h041F, 16'h042F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0416, 16'h0412,
		16'h042C, 16'h042B, 16'h0417, 16'h0428, 16'h042D, 16'h0429, 16'h0427, 16'h042A
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	u2k_pkg::byte_item_t byte_item = '0;
	logic char_valid;
	logic char_stall = 1'b0;
	u2k_pkg::char_item_t char_item;

	u2k_pkg::char_item_t expected_chars[$];
	logic [7:0] text_buf[$];

	logic [1:0] cp_pending = 2'd0;
	logic [20:0] cp_accum = '0;
	logic text_error = 1'b0;

	int src_max = MAX_WAIT;
	int snk_max = MAX_WAIT;
	int stall_left = 0;
	int hold_cycles;
	int cycle_count = 0;
	int fails = 0;
	int n_bytes = 0;
	int n_texts = 0;
	int n_checked = 0;
	int n_unmapped = 0;
	int n_truncated = 0;

	utf8_to_koi8r_decoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int draw_wait(input int max_wait);
		if (max_wait == 0) begin
			return 0;
		end
		return $urandom_range(0, max_wait);
	endfunction

	function automatic logic koi8_of(input logic [20:0] cp, output logic [7:0] code);
		code = QUESTION_MARK;
		if (cp < 21'(ASCII_END)) begin
			code = cp[7:0];
			return 1'b1;
		end
		if (cp == CURRENCY_CP) begin
			code = CURRENCY_KOI8;
			return 1'b1;
		end
		for (int k = 0; k < 128; k++) begin
			if ({5'd0, KOI8R_UPPER[k]} == cp) begin
				code = ASCII_END + 8'(k);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void predict_char(input logic [7:0] b, input logic eot);
		u2k_pkg::char_item_t res;
		logic [7:0] code;
		logic found;
		res = '0;
		if (cp_pending == 2'd0) begin
			if (b < ASCII_END) begin
				cp_accum = 21'(b);
			end else if (b < TWO_BYTE_END) begin
				cp_accum = 21'(b[4:0]);
				cp_pending = 2'd1;
			end else if (b < THREE_BYTE_END) begin
				cp_accum = 21'(b[3:0]);
				cp_pending = 2'd2;
			end else begin
				cp_accum = 21'(b[2:0]);
				cp_pending = 2'd3;
			end
		end else begin
			cp_accum = {cp_accum[14:0], b[5:0]};
			cp_pending = cp_pending - 2'd1;
		end
		if (cp_pending == 2'd0) begin
			found = koi8_of(cp_accum, code);
			res.koi8_code = code;
			res.unmapped = !found;
		end else if (eot) begin
			res.koi8_code = QUESTION_MARK;
			res.truncated = 1'b1;
		end else begin
			return;
		end
		res.text_failed = text_error | res.unmapped | res.truncated;
		res.last_of_text = eot;
		if (eot) begin
			cp_pending = 2'd0;
			cp_accum = '0;
			text_error = 1'b0;
			n_texts++;
		end else begin
			text_error = res.text_failed;
		end
		if (res.unmapped) n_unmapped++;
		if (res.truncated) n_truncated++;
		expected_chars.push_back(res);
	endfunction

	task automatic check_char(input u2k_pkg::char_item_t got);
		u2k_pkg::char_item_t want;
		if (expected_chars.size() == 0) begin
			$error("Unexpected item: koi8_code %02h", got.koi8_code);
			fails++;
			return;
		end
		want = expected_chars.pop_front();
		n_checked++;
		if (got.koi8_code !== want.koi8_code) begin
			$error("koi8_code: expected %02h, got %02h", want.koi8_code, got.koi8_code);
			fails++;
		end
		if (got.unmapped !== want.unmapped) begin
			$error("unmapped: expected %b, got %b", want.unmapped, got.unmapped);
			fails++;
		end
		if (got.truncated !== want.truncated) begin
			$error("truncated: expected %b, got %b", want.truncated, got.truncated);
			fails++;
		end
		if (got.text_failed !== want.text_failed) begin
			$error("text_failed: expected %b, got %b", want.text_failed, got.text_failed);
			fails++;
		end
		if (got.last_of_text !== want.last_of_text) begin
			$error("last_of_text: expected %b, got %b", want.last_of_text, got.last_of_text);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) begin
			check_char(char_item);
			hold_cycles = draw_wait(snk_max);
			if (hold_cycles > 0) begin
				char_stall <= 1'b1;
				stall_left = hold_cycles;
			end
		end else if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0) char_stall <= 1'b0;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		u2k_pkg::byte_item_t item;
		int gap;
		gap = draw_wait(src_max);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.text_byte = b;
		item.end_of_text = eot;
		byte_valid <= 1'b1;
		byte_item <= item;
		do @(posedge clk); while (byte_stall);
		n_bytes++;
		predict_char(b, eot);
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_ascii_extremes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
	endtask

	// The unmapped character in the middle makes the final one carry the text error.
	task automatic test_two_byte_chars();
		send_byte(8'hC2, 1'b0);
		send_byte(8'hA4, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hD0, 1'b0);
		send_byte(8'hB0, 1'b1);
	endtask

	task automatic test_three_byte_chars();
		send_byte(8'hE2, 1'b0);
		send_byte(8'h94, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	task automatic test_four_byte_chars();
		send_byte(8'hF7, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	// Bytes 0x80 to 0xBF used as a lead start a two-byte sequence.
	task automatic test_stray_leads();
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_truncated_texts();
		send_byte(8'hE2, 1'b0);
		send_byte(8'h94, 1'b1);
		send_byte(8'hD0, 1'b1);
	endtask

	task automatic append_char(input logic [20:0] cp, input int len);
		case (len)
			1: text_buf.push_back({1'b0, cp[6:0]});
			2: begin
				text_buf.push_back({3'b110, cp[10:6]});
				text_buf.push_back({2'b10, cp[5:0]});
			end
			3: begin
				text_buf.push_back({4'b1110, cp[15:12]});
				text_buf.push_back({2'b10, cp[11:6]});
				text_buf.push_back({2'b10, cp[5:0]});
			end
			default: begin
				text_buf.push_back({5'b11110, cp[20:18]});
				text_buf.push_back({2'b10, cp[17:12]});
				text_buf.push_back({2'b10, cp[11:6]});
				text_buf.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// Mostly well-formed texts with random characters; some noise and cut-off texts.
	task automatic build_text();
		int n_chars;
		int kind;
		int len;
		logic [20:0] cp;
		text_buf.delete();
		if ($urandom_range(0, 9) == 0) begin
			n_chars = $urandom_range(1, 8);
			repeat (n_chars) text_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n_chars = $urandom_range(1, 10);
		len = 1;
		repeat (n_chars) begin
			kind = $urandom_range(0, 19);
			if (kind <= 5) begin
				len = 1;
				append_char(21'($urandom_range(0, 127)), len);
			end else if (kind <= 12) begin
				cp = {5'd0, KOI8R_UPPER[$urandom_range(0, 127)]};
				len = (cp < 21'h800) ? 2 : 3;
				if ($urandom_range(0, 7) == 0) len++;
				append_char(cp, len);
			end else if (kind == 13) begin
				len = 2;
				append_char(CURRENCY_CP, len);
			end else if (kind <= 16) begin
				len = $urandom_range(2, 4);
				cp = 21'($urandom);
				if (len == 2) cp[20:11] = '0;
				if (len == 3) cp[20:16] = '0;
				append_char(cp, len);
			end else if (kind == 17) begin
				len = 1;
				text_buf.push_back(8'($urandom_range(0, 255)));
			end else if (kind == 18) begin
				len = 2;
				text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
				text_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				len = 2;
				append_char(21'($urandom_range(0, 127)), len);
			end
		end
		if (len > 1 && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, len - 1)) void'(text_buf.pop_back());
		end
	endtask

	task automatic test_random_texts(input int n_items);
		int sent;
		logic drained;
		sent = 0;
		drained = 1'b0;
		while (sent < n_items) begin
			if ($urandom_range(0, 7) == 0) src_max = $urandom_range(0, 1) ? MAX_WAIT : 0;
			if ($urandom_range(0, 7) == 0) snk_max = $urandom_range(0, 1) ? MAX_WAIT : 0;
			build_text();
			foreach (text_buf[i]) begin
				send_byte(text_buf[i], i == text_buf.size() - 1);
			end
			sent += text_buf.size();
			if (!drained && sent >= n_items / 2) begin
				wait_drained();
				drained = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ascii_extremes();
		test_two_byte_chars();
		test_three_byte_chars();
		test_four_byte_chars();
		test_stray_leads();
		test_truncated_texts();
		test_random_texts(725);
		wait_drained();
		$display("Sent %0d bytes in %0d texts; %0d decoded items checked.",
			n_bytes, n_texts, n_checked);
		$display("Among them %0d unmapped characters and %0d cut-off texts.",
			n_unmapped, n_truncated);
		if (fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
